// File: sv/dpd_pkg.sv
`timescale 1ns / 1ps

package dpd_pkg;

   // Longest payload that is passed on before a packet is flagged as too long.
   localparam int MaxPayload = 128;
   localparam int CountWidth = $clog2(MaxPayload + 1);

   // Framing marks and acknowledge characters.
   localparam logic [7:0] MARK_START = 8'h24;
   localparam logic [7:0] MARK_END   = 8'h23;
   localparam logic [7:0] ACK_GOOD   = 8'h2b;
   localparam logic [7:0] ACK_BAD    = 8'h2d;

   // ASCII bases for hex digit decoding.
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
   localparam logic [1:0] KIND_GOOD      = 2'd1;
   localparam logic [1:0] KIND_BAD_SUM   = 2'd2;
   localparam logic [1:0] KIND_TOO_LONG  = 2'd3;

   // Decoded checksum digit; the nibble is zero when the character is not hex.
   typedef struct packed {
      logic       is_hex;
      logic [3:0] nibble;
   } hex_digit_type;

endpackage

// File: sv/dpd_hex_decode.sv
`timescale 1ns / 1ps

module dpd_hex_decode (
   input  logic [7:0]             char_in,
   output dpd_pkg::hex_digit_type digit
);
   import dpd_pkg::*;

   logic [7:0] off_digit;
   logic [7:0] off_upper;
   logic [7:0] off_lower;

   assign off_digit = char_in - CHAR_ZERO;
   assign off_upper = char_in - CHAR_UPPER_A;
   assign off_lower = char_in - CHAR_LOWER_A;

   // The subtractions wrap for characters below each base, so a single
   // unsigned compare checks both ends of each range.
   always_comb begin
      digit = '0;
      if (off_lower < 8'd6) begin
         digit.is_hex = 1'b1;
         digit.nibble = off_lower[3:0] + 4'd10;
      end else if (off_digit < 8'd10) begin
         digit.is_hex = 1'b1;
         digit.nibble = off_digit[3:0];
      end else if (off_upper < 8'd6) begin
         digit.is_hex = 1'b1;
         digit.nibble = off_upper[3:0] + 4'd10;
      end
   end

endmodule

// File: sv/debug_packet_deframer_top.sv
`timescale 1ns / 1ps

// Receive-side deframer for remote-debug serial packets of the form
// '$' payload '#' hex hex. One received byte is taken per request transaction,
// and the block accepts a byte in every clock cycle as long as the result
// register is free or is being emptied in the same cycle; a byte is fully
// handled in the cycle it is accepted and its result, if any, appears on the
// response side in the next cycle. Bytes before '$' are dropped silently. Each
// payload byte is echoed as a response transaction of kind 0 and added to an
// 8-bit modulo-256 sum. The second checksum digit closes the packet with one
// response transaction marked last: kind 1 (good, ack '+'), kind 2 (checksum
// mismatch or non-hex digit, ack '-'), or kind 3 (payload longer than
// MaxPayload, ack '-'). Bytes past MaxPayload give no response but still
// enter the sum. Markers and checksum digits produce no response of their own.
// req_stall is high only while a result is held and the response side stalls.

module debug_packet_deframer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_ack_byte,
   output logic [7:0] rsp_payload_length,
   output logic [7:0] rsp_sent_checksum,
   output logic [7:0] rsp_computed_checksum,
   output logic       rsp_last
);
   import dpd_pkg::*;

   // Packet phases.
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_HI   = 2'd2;
   localparam logic [1:0] PH_LO   = 2'd3;

   // Packet state.
   logic [1:0]            phase_ff, phase_in;
   logic [7:0]            sum_ff, sum_in;
   logic [3:0]            high_digit_ff, high_digit_in;
   logic                  digit_invalid_ff, digit_invalid_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  overflowed_ff, overflowed_in;

   // Result register.
   logic       rsp_valid_ff;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] payload_ff, payload_in;
   logic [7:0] ack_ff, ack_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] sent_ff, sent_in;
   logic [7:0] computed_ff, computed_in;
   logic       last_ff, last_in;
   logic       produce;

   logic          accept;
   hex_digit_type digit;
   logic [7:0]    sent_sum;

   dpd_hex_decode u_hex (
      .char_in (req_rx_byte),
      .digit   (digit)
   );

   // The result register frees up in the same cycle it is read out, so a
   // stalled response side is the only thing that holds back new bytes.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign sent_sum  = {high_digit_ff, digit.nibble};

   always_comb begin
      phase_in         = phase_ff;
      sum_in           = sum_ff;
      high_digit_in    = high_digit_ff;
      digit_invalid_in = digit_invalid_ff;
      count_in         = count_ff;
      overflowed_in    = overflowed_ff;
      produce          = 1'b0;
      kind_in          = KIND_PAYLOAD;
      payload_in       = '0;
      ack_in           = '0;
      length_in        = '0;
      sent_in          = '0;
      computed_in      = '0;
      last_in          = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (req_rx_byte == MARK_START) begin
               sum_in           = '0;
               high_digit_in    = '0;
               digit_invalid_in = 1'b0;
               count_in         = '0;
               overflowed_in    = 1'b0;
               phase_in         = PH_BODY;
            end
         end
         PH_BODY: begin
            if (req_rx_byte == MARK_END) begin
               phase_in = PH_HI;
            end else begin
               sum_in = sum_ff + req_rx_byte;
               if (count_ff >= CountWidth'(MaxPayload)) begin
                  overflowed_in = 1'b1;
               end else begin
                  count_in   = count_ff + CountWidth'(1);
                  produce    = 1'b1;
                  payload_in = req_rx_byte;
               end
            end
         end
         PH_HI: begin
            high_digit_in = digit.nibble;
            if (!digit.is_hex) begin
               digit_invalid_in = 1'b1;
            end
            phase_in = PH_LO;
         end
         default: begin
            if (!digit.is_hex) begin
               digit_invalid_in = 1'b1;
            end
            produce = 1'b1;
            if (overflowed_ff) begin
               kind_in = KIND_TOO_LONG;
            end else if (!digit.is_hex || digit_invalid_ff || sent_sum != sum_ff) begin
               kind_in = KIND_BAD_SUM;
            end else begin
               kind_in = KIND_GOOD;
            end
            ack_in      = (kind_in == KIND_GOOD) ? ACK_GOOD : ACK_BAD;
            length_in   = 8'(count_ff);
            sent_in     = sent_sum;
            computed_in = sum_ff;
            last_in     = 1'b1;
            phase_in    = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         sum_ff           <= '0;
         high_digit_ff    <= '0;
         digit_invalid_ff <= 1'b0;
         count_ff         <= '0;
         overflowed_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         sum_ff           <= sum_in;
         high_digit_ff    <= high_digit_in;
         digit_invalid_ff <= digit_invalid_in;
         count_ff         <= count_in;
         overflowed_ff    <= overflowed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload fields carry no reset; they are qualified by rsp_valid.
   always_ff @(posedge clock) begin
      if (accept && produce) begin
         kind_ff     <= kind_in;
         payload_ff  <= payload_in;
         ack_ff      <= ack_in;
         length_ff   <= length_in;
         sent_ff     <= sent_in;
         computed_ff <= computed_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = kind_ff;
   assign rsp_payload_byte      = payload_ff;
   assign rsp_ack_byte          = ack_ff;
   assign rsp_payload_length    = length_ff;
   assign rsp_sent_checksum     = sent_ff;
   assign rsp_computed_checksum = computed_ff;
   assign rsp_last              = last_ff;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import dpd_pkg::*;

   // Parser phases of the deframer as the scoreboard tracks them.
   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_BODY,
      SCAN_HIGH,
      SCAN_LOW
   } scan_phase_type;

   // One response transaction, field for field as the block presents it.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic [7:0] ack_byte;
      logic [7:0] payload_length;
      logic [7:0] sent_checksum;
      logic [7:0] computed_checksum;
      logic       last;
   } frame_result_type;

   // Kinds of packet that the random stimulus builds.
   typedef enum int {
      PKT_GOOD,
      PKT_BAD_SUM,
      PKT_BAD_DIGIT,
      PKT_TRUNCATED
   } packet_shape_type;

   // Value of an ASCII hex digit, or 16 when the character is not one.
   function automatic int nibble_of(input logic [7:0] c);
      if (c >= CHAR_LOWER_A && c < CHAR_LOWER_A + 8'd6) return int'(c - CHAR_LOWER_A) + 10;
      if (c >= CHAR_ZERO && c < CHAR_ZERO + 8'd10) return int'(c - CHAR_ZERO);
      if (c >= CHAR_UPPER_A && c < CHAR_UPPER_A + 8'd6) return int'(c - CHAR_UPPER_A) + 10;
      return 16;
   endfunction

   class deframe_scoreboard;
      scan_phase_type   phase;
      logic [7:0]       running_sum;
      logic [3:0]       high_nibble;
      bit               digit_bad;
      int               payload_count;
      bit               overflow_seen;
      frame_result_type pending_frames[$];
      int               mismatch_count;

      function new();
         phase          = SCAN_IDLE;
         running_sum    = '0;
         high_nibble    = '0;
         digit_bad      = 1'b0;
         payload_count  = 0;
         overflow_seen  = 1'b0;
         mismatch_count = 0;
      endfunction

      // Advance the parser by one accepted byte and queue the result it causes.
      function void absorb_rx_byte(input logic [7:0] c);
         frame_result_type r;
         int               v;
         logic [7:0]       sent;
         r = '0;
         case (phase)
            SCAN_IDLE: begin
               if (c == MARK_START) begin
                  running_sum   = '0;
                  high_nibble   = '0;
                  digit_bad     = 1'b0;
                  payload_count = 0;
                  overflow_seen = 1'b0;
                  phase         = SCAN_BODY;
               end
            end
            SCAN_BODY: begin
               if (c == MARK_END) begin
                  phase = SCAN_HIGH;
               end else begin
                  running_sum = running_sum + c;
                  if (payload_count >= MaxPayload) begin
                     overflow_seen = 1'b1;
                  end else begin
                     payload_count++;
                     r.kind         = KIND_PAYLOAD;
                     r.payload_byte = c;
                     pending_frames.push_back(r);
                  end
               end
            end
            SCAN_HIGH: begin
               v = nibble_of(c);
               if (v > 15) begin
                  digit_bad = 1'b1;
                  v = 0;
               end
               high_nibble = v[3:0];
               phase       = SCAN_LOW;
            end
            default: begin
               v = nibble_of(c);
               if (v > 15) begin
                  digit_bad = 1'b1;
                  v = 0;
               end
               sent = {high_nibble, v[3:0]};
               if (overflow_seen) r.kind = KIND_TOO_LONG;
               else if (digit_bad || sent != running_sum) r.kind = KIND_BAD_SUM;
               else r.kind = KIND_GOOD;
               r.ack_byte          = (r.kind == KIND_GOOD) ? ACK_GOOD : ACK_BAD;
               r.payload_length    = payload_count[7:0];
               r.sent_checksum     = sent;
               r.computed_checksum = running_sum;
               r.last              = 1'b1;
               pending_frames.push_back(r);
               phase = SCAN_IDLE;
            end
         endcase
      endfunction

      // Compare one accepted response transaction with the oldest expectation.
      function void check_frame(input frame_result_type got);
         frame_result_type want;
         bit               differs;
         if (pending_frames.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected: kind %0d byte %h ack %h len %0d sent %h calc %h last %b",
                        got.kind, got.payload_byte, got.ack_byte, got.payload_length,
                        got.sent_checksum, got.computed_checksum, got.last);
            return;
         end
         want = pending_frames.pop_front();
         differs = (got.kind !== want.kind) || (got.payload_byte !== want.payload_byte) ||
                   (got.ack_byte !== want.ack_byte) ||
                   (got.payload_length !== want.payload_length) ||
                   (got.sent_checksum !== want.sent_checksum) ||
                   (got.computed_checksum !== want.computed_checksum) ||
                   (got.last !== want.last);
         if (differs) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("expected kind %0d byte %h ack %h len %0d sent %h calc %h last %b",
                        want.kind, want.payload_byte, want.ack_byte, want.payload_length,
                        want.sent_checksum, want.computed_checksum, want.last);
               $display("actual   kind %0d byte %h ack %h len %0d sent %h calc %h last %b",
                        got.kind, got.payload_byte, got.ack_byte, got.payload_length,
                        got.sent_checksum, got.computed_checksum, got.last);
            end
         end
      endfunction

      function int outstanding();
         return pending_frames.size();
      endfunction
   endclass

   // The clock runs at 100 MHz. The cycle limit is far above the slowest legal run:
   // roughly 800 bytes, each with the longest send gap and the longest receive stall,
   // plus the long receiver hold-off.
   localparam int ClockPeriod = 10;
   localparam int CycleLimit  = 200000;
   localparam int RandomBytes = 450;
   localparam int HoldCycles  = 400;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_ack_byte;
   logic [7:0] rsp_payload_length;
   logic [7:0] rsp_sent_checksum;
   logic [7:0] rsp_computed_checksum;
   logic       rsp_last;

   deframe_scoreboard scoreboard = new();

   // When clear, neither side inserts gaps, giving back-to-back stretches.
   bit idle_on = 1'b1;
   // Raised once by the stimulus to start the long receiver hold-off.
   bit hold_go = 1'b0;
   logic hold_rsp = 1'b0;
   int rsp_wait = 0;
   int cycle_count = 0;
   int packet_bytes = 0;

   debug_packet_deframer_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_ack_byte         (rsp_ack_byte),
      .rsp_payload_length   (rsp_payload_length),
      .rsp_sent_checksum    (rsp_sent_checksum),
      .rsp_computed_checksum(rsp_computed_checksum),
      .rsp_last             (rsp_last)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // A watchdog fails the run once the cycle count passes the limit, as when the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Response side. Every accepted response transaction goes to the scoreboard,
   // and a fresh stall length is drawn after each one. The long hold-off wins over
   // the per-transaction stall so the block backs up into its request side.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scoreboard.check_frame('{kind: rsp_kind, payload_byte: rsp_payload_byte,
                                  ack_byte: rsp_ack_byte, payload_length: rsp_payload_length,
                                  sent_checksum: rsp_sent_checksum,
                                  computed_checksum: rsp_computed_checksum,
                                  last: rsp_last});
         rsp_wait = idle_on ? $urandom_range(0, 10) : 0;
      end
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // The hold-off is counted in its own process; the sender keeps offering bytes
   // meanwhile, so the result register fills and req_stall must rise.
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Offer one byte as a request transaction after an optional gap, and hand it
   // to the scoreboard at the edge where it is accepted. The valid is only lowered
   // when a gap is drawn, so back-to-back bytes keep it high.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      scoreboard.absorb_rx_byte(b);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 4'd10) return CHAR_ZERO + n;
      return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + (n - 4'd10);
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (nibble_of(c) != 16);
      return c;
   endfunction

   // Build and send one packet: start mark, payload, end mark and two digits,
   // with the checksum made good, wrong or non-hex, or the packet cut short
   // after its payload.
   task automatic send_packet(input int len, input packet_shape_type shape);
      logic [7:0] sum;
      logic [7:0] c;
      logic [7:0] hi_char;
      logic [7:0] lo_char;
      sum = '0;
      send_byte(MARK_START);
      for (int i = 0; i < len; i++) begin
         // The end mark is kept out of the payload so the packet keeps its length.
         do c = 8'($urandom_range(0, 255)); while (c == MARK_END);
         sum = sum + c;
         send_byte(c);
      end
      packet_bytes += len + 1;
      if (shape == PKT_TRUNCATED) return;
      if (shape == PKT_BAD_SUM) sum = sum ^ (8'd1 << $urandom_range(0, 7));
      hi_char = hex_char(sum[7:4], 1'($urandom_range(0, 1)));
      lo_char = hex_char(sum[3:0], 1'($urandom_range(0, 1)));
      if (shape == PKT_BAD_DIGIT) begin
         case ($urandom_range(0, 2))
            0: hi_char = non_hex_char();
            1: lo_char = non_hex_char();
            default: begin
               hi_char = non_hex_char();
               lo_char = non_hex_char();
            end
         endcase
      end
      send_byte(MARK_END);
      send_byte(hi_char);
      send_byte(lo_char);
      packet_bytes += 3;
   endtask

   // Directed bytes: a dropped byte before any start mark, an empty good packet,
   // payload bytes 00 and ff with a start mark inside the payload, mixed-case
   // letter digits, non-hex digits in both positions (the second one an end mark),
   // and a plain checksum mismatch.
   logic [7:0] directed_bytes[] = '{
      8'h55,
      MARK_START, MARK_END, CHAR_ZERO, CHAR_ZERO,
      MARK_START, 8'h00, 8'hff, MARK_START, MARK_END, CHAR_ZERO + 8'd2, CHAR_ZERO + 8'd3,
      MARK_START, 8'hab, MARK_END, CHAR_LOWER_A, CHAR_UPPER_A + 8'd1,
      MARK_START, MARK_END, 8'h47, MARK_END,
      MARK_START, 8'h01, MARK_END, CHAR_ZERO, CHAR_ZERO + 8'd2
   };

   initial begin
      int pick;
      int len;
      packet_shape_type shape;

      // Reset is held from the start and released once.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

      // Long hold-off with the sender running flat out; a full-length packet and one
      // just past the limit are sent, starting while the response side is blocked.
      idle_on = 1'b0;
      hold_go = 1'b1;
      send_packet(MaxPayload, PKT_GOOD);
      send_packet(MaxPayload + 2, PKT_GOOD);
      idle_on = 1'b1;

      packet_bytes = 0;
      while (packet_bytes < RandomBytes) begin
         // Switch now and then between idling and back-to-back traffic.
         if ($urandom_range(0, 15) == 0) idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // Line noise between packets, which the block drops unless a byte is a start mark.
            repeat ($urandom_range(1, 4)) begin
               send_byte(8'($urandom_range(0, 255)));
            end
         end
         pick = $urandom_range(0, 199);
         if (pick < 3) len = MaxPayload;
         else if (pick < 6) len = $urandom_range(MaxPayload + 1, MaxPayload + 6);
         else len = $urandom_range(0, 12);
         pick = $urandom_range(0, 99);
         if (pick < 70) shape = PKT_GOOD;
         else if (pick < 82) shape = PKT_BAD_SUM;
         else if (pick < 94) shape = PKT_BAD_DIGIT;
         else shape = PKT_TRUNCATED;
         send_packet(len, shape);
      end
      req_valid <= 1'b0;

      // Drain, then wait on so that any stray response can still show up.
      while (scoreboard.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (scoreboard.mismatch_count == 0 && scoreboard.outstanding() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
